### sv/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int USED_W = 3;

   // Small result queue between the decoder and the result port
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
   localparam logic [CP_W-1:0] SURR_LOW   = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HIGH  = 21'h00DFFF;
   localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
   localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
   localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;
   localparam logic [CP_W-1:0] MAX_LEN2   = 21'h0007FF;

   localparam logic [BYTE_W-1:0] LEAD2_BASE   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_BASE   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_BASE   = 8'hF0;
   localparam logic [BYTE_W-1:0] ILLEGAL_BASE = 8'hF8;
   localparam logic [BYTE_W-1:0] CONT_BASE    = 8'h80;

   localparam logic [USED_W-1:0] LEN_NONE = 3'd0;
   localparam logic [USED_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [USED_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [USED_W-1:0] LEN_THREE = 3'd3;
   localparam logic [USED_W-1:0] LEN_FOUR = 3'd4;

   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic [USED_W-1:0] bytes_used;
      logic              invalid;
      logic              last;
   } result_type;

   // Zero, one or two results caused by one byte
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

endpackage

### sv/u8dec_decode.sv
// ----------------------------------------------------------------------------
// u8dec_decode
// Sequence state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module u8dec_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [u8dec_pkg::BYTE_W-1:0]        in_byte,
   output u8dec_pkg::decode_type               dec
);

   logic [u8dec_pkg::USED_W-1:0] seq_len_ff, seq_len_in;
   logic [u8dec_pkg::USED_W-1:0] seen_ff, seen_in;
   logic [u8dec_pkg::CP_W-1:0]   acc_ff, acc_in;

   // byte handled with no sequence open
   logic                         st_has;
   u8dec_pkg::result_type        st_res;
   logic [u8dec_pkg::USED_W-1:0] st_len;
   logic [u8dec_pkg::CP_W-1:0]   st_acc;

   logic [u8dec_pkg::CP_W-1:0]   acc_shift;
   logic [u8dec_pkg::USED_W-1:0] seen_inc;
   logic                         bad;

   always_comb begin
      st_has              = 1'b0;
      st_res.code_point   = {13'd0, in_byte};
      st_res.bytes_used   = u8dec_pkg::LEN_ONE;
      st_res.invalid      = 1'b0;
      st_res.last         = 1'b1;
      st_len              = u8dec_pkg::LEN_NONE;
      st_acc              = '0;
      if (in_byte < u8dec_pkg::CONT_BASE) begin
         st_has = 1'b1;
      end else if (in_byte < u8dec_pkg::LEAD2_BASE ||
                   in_byte >= u8dec_pkg::ILLEGAL_BASE) begin
         st_has            = 1'b1;
         st_res.code_point = u8dec_pkg::REPL_CHAR;
         st_res.invalid    = 1'b1;
      end else if (in_byte < u8dec_pkg::LEAD3_BASE) begin
         st_len = u8dec_pkg::LEN_TWO;
         st_acc = {16'd0, in_byte[4:0]};
      end else if (in_byte < u8dec_pkg::LEAD4_BASE) begin
         st_len = u8dec_pkg::LEN_THREE;
         st_acc = {17'd0, in_byte[3:0]};
      end else begin
         st_len = u8dec_pkg::LEN_FOUR;
         st_acc = {18'd0, in_byte[2:0]};
      end
   end

   assign acc_shift = {acc_ff[14:0], in_byte[5:0]};
   assign seen_inc  = seen_ff + u8dec_pkg::LEN_ONE;

   // overlong, surrogate and range check on a completed sequence
   always_comb begin
      bad = (acc_shift > u8dec_pkg::MAX_SCALAR) ||
            (acc_shift >= u8dec_pkg::SURR_LOW && acc_shift <= u8dec_pkg::SURR_HIGH);
      case (seq_len_ff)
         u8dec_pkg::LEN_TWO:   bad = bad || acc_shift < u8dec_pkg::MIN_LEN2 ||
                                     acc_shift > u8dec_pkg::MAX_LEN2;
         u8dec_pkg::LEN_THREE: bad = bad || acc_shift < u8dec_pkg::MIN_LEN3;
         u8dec_pkg::LEN_FOUR:  bad = bad || acc_shift < u8dec_pkg::MIN_LEN4;
         default:              bad = 1'b1;
      endcase
   end

   always_comb begin
      dec        = '0;
      seq_len_in = seq_len_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      if (seq_len_ff == u8dec_pkg::LEN_NONE) begin
         dec.count  = {1'b0, st_has};
         dec.first  = st_res;
         seq_len_in = st_len;
         seen_in    = st_has ? u8dec_pkg::LEN_NONE : u8dec_pkg::LEN_ONE;
         acc_in     = st_acc;
      end else if (in_byte[7:6] == 2'b10) begin
         acc_in  = acc_shift;
         seen_in = seen_inc;
         if (seen_inc >= seq_len_ff) begin
            dec.count            = 2'd1;
            dec.first.code_point = bad ? u8dec_pkg::REPL_CHAR : acc_shift;
            dec.first.bytes_used = seq_len_ff;
            dec.first.invalid    = bad;
            dec.first.last       = 1'b1;
            seq_len_in           = u8dec_pkg::LEN_NONE;
            seen_in              = u8dec_pkg::LEN_NONE;
            acc_in               = '0;
         end
      end else begin
         // interrupted sequence: replacement for what was seen, then restart
         dec.count            = st_has ? 2'd2 : 2'd1;
         dec.first.code_point = u8dec_pkg::REPL_CHAR;
         dec.first.bytes_used = seen_ff;
         dec.first.invalid    = 1'b1;
         dec.first.last       = ~st_has;
         dec.second           = st_res;
         seq_len_in           = st_len;
         seen_in              = st_has ? u8dec_pkg::LEN_NONE : u8dec_pkg::LEN_ONE;
         acc_in               = st_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= u8dec_pkg::LEN_NONE;
         seen_ff    <= u8dec_pkg::LEN_NONE;
         acc_ff     <= '0;
      end else if (advance) begin
         seq_len_ff <= seq_len_in;
         seen_ff    <= seen_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

### sv/u8dec_result_fifo.sv
// ----------------------------------------------------------------------------
// u8dec_result_fifo
// Four-entry result queue; takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module u8dec_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  u8dec_pkg::result_type  push_first,
   input  u8dec_pkg::result_type  push_second,
   input  logic                   pop,
   output u8dec_pkg::result_type  head,
   output logic                   not_empty,
   output logic                   room
);

   u8dec_pkg::result_type mem_ff [u8dec_pkg::FIFO_DEPTH];

   logic [u8dec_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8dec_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8dec_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [u8dec_pkg::PTR_W-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 2'd1;
   assign head        = mem_ff[rd_ptr_ff];
   assign not_empty   = cnt_ff != '0;
   // space for two after this cycle's pop
   assign room        = (cnt_ff <= 3'd2) || (cnt_ff == 3'd3 && pop);

   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign cnt_in    = cnt_ff + {1'b0, push_count} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### sv/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Decodes a UTF-8 byte stream into code points with length and error flag.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then decoded into the
//   result queue once the queue has room for two results.
// Throughput: 1 byte per cycle while the queue has room; a byte that yields
//   two results gives them out in turn; the four-entry queue holds the extra.
// Reset: synchronous; clears the open sequence, input register and queue.
module utf8_stream_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   // byte input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [u8dec_pkg::BYTE_W-1:0]       req_in_byte,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [u8dec_pkg::CP_W-1:0]         rsp_code_point,
   output logic [u8dec_pkg::USED_W-1:0]       rsp_bytes_used,
   output logic                               rsp_invalid,
   output logic                               rsp_last
);

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [u8dec_pkg::BYTE_W-1:0]  in_byte_ff;

   logic                          req_take;
   logic                          advance;   // byte in the register is decoded
   logic                          pop;
   logic                          room;
   logic                          not_empty;
   u8dec_pkg::decode_type         dec;
   u8dec_pkg::result_type         head;
   logic [1:0]                    push_count;

   // The held byte moves on only when the queue can take two items, so a
   // byte never has to be split across cycles.
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign pop       = not_empty && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   u8dec_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .dec     (dec)
   );

   // nothing is written unless the byte really advances
   assign push_count = advance ? dec.count : 2'd0;

   u8dec_result_fifo u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (dec.first),
      .push_second (dec.second),
      .pop         (pop),
      .head        (head),
      .not_empty   (not_empty),
      .room        (room)
   );

   assign rsp_valid      = not_empty;
   assign rsp_code_point = head.code_point;
   assign rsp_bytes_used = head.bytes_used;
   assign rsp_invalid    = head.invalid;
   assign rsp_last       = head.last;

   // --- checks ---------------------------------------------------------------

   // a result always covers one to four bytes
   a_used_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bytes_used != 3'd0 && rsp_bytes_used <= 3'd4))
      else $error("result with bytes_used out of range");

   // an invalid result always carries the replacement character
   a_invalid_repl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_code_point == u8dec_pkg::REPL_CHAR)
      else $error("invalid result without replacement character");

   // of a pair, the first result is never the last one of its byte
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> (!dec.first.last && dec.second.last))
      else $error("result pair with wrong last flags");

   // a decoded byte that gives a single result marks it with last
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd1 |-> dec.first.last)
      else $error("single result without last");

endmodule
